// ----- hw/rtl/sact_pkg.sv -----
package sact_pkg;

	localparam int SET_COUNT_DEF    = 64;
	localparam int WAY_COUNT_DEF    = 4;
	localparam int ADDRESS_BITS_DEF = 32;
	localparam int STAMP_BITS_DEF   = 32;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam logic KIND_LOOKUP  = 1'b0;
	localparam logic KIND_INSTALL = 1'b1;

	localparam logic POLICY_LRU    = 1'b0;
	localparam logic POLICY_RANDOM = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] line_address;
		logic        is_store;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        evicted_valid;
		logic        evicted_dirty;
		logic [31:0] evicted_line_address;
		logic [31:0] read_accesses;
		logic [31:0] write_accesses;
		logic [31:0] read_misses;
		logic [31:0] write_misses;
		logic [31:0] dirty_evictions;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_en;
		logic take;
		logic eval;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
	} status_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		lfsr_next = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
	endfunction

	function automatic int set_index_width(input int sets);
		int b;
		b = 0;
		for (int i = 0; i < 13; i++)
			if ((2 << b) <= sets) b++;
		return b;
	endfunction

endpackage

// ----- hw/rtl/sact_ram.sv -----
module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hw/rtl/sact_ctrl.sv -----
module sact_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  sact_pkg::status_t status,
	output sact_pkg::cmd_t    cmd
);
	import sact_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				rsp_valid = 1'b1;
				if (rsp_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule

// ----- hw/rtl/sact_datapath.sv -----
module sact_datapath #(
	parameter int SET_COUNT    = sact_pkg::SET_COUNT_DEF,
	parameter int WAY_COUNT    = sact_pkg::WAY_COUNT_DEF,
	parameter int ADDRESS_BITS = sact_pkg::ADDRESS_BITS_DEF,
	parameter int STAMP_BITS   = sact_pkg::STAMP_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sact_pkg::cmd_t    cmd,
	output sact_pkg::status_t status,
	input  sact_pkg::req_t    req,
	input  logic              policy,
	output sact_pkg::rsp_t    rsp
);
	import sact_pkg::*;

	localparam int IB    = set_index_width(SET_COUNT);
	localparam int SETS  = 1 << IB;
	localparam int SB    = (IB > 0) ? IB : 1;
	localparam int TAGB  = ADDRESS_BITS - IB;
	localparam int WB    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	// one memory row holds a whole set: per way valid, dirty, tag, stamp
	localparam int ENTB  = 2 + TAGB + STAMP_BITS;
	localparam int ROWB  = ENTB * WAY_COUNT;
	// LFSR modulo WAY_COUNT by reciprocal multiply, exact over all 16-bit values
	localparam int     RL  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 0;
	localparam int     RK  = 16 + RL;
	localparam int     RPB = 17 + RK;
	localparam longint RM  = ((longint'(1) << RK) + longint'(WAY_COUNT) - 1)
		/ longint'(WAY_COUNT);

	logic [ADDRESS_BITS-1:0] addr_q;
	logic                    kind_q, store_q;
	logic [STAMP_BITS-1:0]   stamp_q;
	logic [SB-1:0]           set_q, clr_q;
	logic [15:0]             lfsr_q;
	logic [31:0]             rd_q, wr_q, rdm_q, wrm_q, dev_q;
	logic                    hit_q, evv_q, evd_q;
	logic [31:0]             eva_q;
	logic [ROWB-1:0]         row_rd, row_wd;
	logic                    we;
	logic [SB-1:0]           waddr;
	logic [TAGB-1:0]         tag;

	logic [WAY_COUNT-1:0]  v, d;
	logic [TAGB-1:0]       t [WAY_COUNT];
	logic [STAMP_BITS-1:0] s [WAY_COUNT];

	logic [WAY_COUNT-1:0]  hitv;
	logic [WB-1:0]         hway, vway, lru_way, rnd_way, way;
	logic                  any_hit, found_inv;
	logic [STAMP_BITS-1:0] oldest;
	logic [15:0]           lfsr_n;
	logic [RPB-1:0]        rnd_prod;
	logic [15:0]           rnd_quo, rnd_rem;
	logic [ADDRESS_BITS-1:0] ev_full;

	assign tag = addr_q[ADDRESS_BITS-1:IB];

	always_comb begin
		for (int w = 0; w < WAY_COUNT; w++) begin
			v[w] = row_rd[w*ENTB + ENTB - 1];
			d[w] = row_rd[w*ENTB + ENTB - 2];
			t[w] = row_rd[w*ENTB + STAMP_BITS +: TAGB];
			s[w] = row_rd[w*ENTB +: STAMP_BITS];
			hitv[w] = v[w] && (t[w] == tag);
		end
	end

	always_comb begin
		any_hit   = 1'b0;
		hway      = '0;
		found_inv = 1'b0;
		lru_way   = '0;
		oldest    = s[0];
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (hitv[w]) begin
				any_hit = 1'b1;
				hway    = WB'(w);
			end
		end
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (!found_inv) begin
				if (!v[w]) begin
					found_inv = 1'b1;
					lru_way   = WB'(w);
				end else if (s[w] < oldest) begin
					oldest  = s[w];
					lru_way = WB'(w);
				end
			end
		end
	end

	assign lfsr_n   = lfsr_next(lfsr_q);
	assign rnd_prod = RPB'(lfsr_n) * RPB'(RM);
	assign rnd_quo  = rnd_prod[RK +: 16];
	assign rnd_rem  = lfsr_n - rnd_quo * 16'(WAY_COUNT);
	assign rnd_way  = WB'(rnd_rem);
	assign vway    = (policy == POLICY_RANDOM) ? rnd_way : lru_way;
	assign way     = (kind_q == KIND_INSTALL) ? vway : hway;
	assign ev_full = {t[vway], {IB{1'b0}}} | ADDRESS_BITS'(set_q[IB > 0 ? IB-1 : 0:0]
		& {SB{IB > 0}});

	always_comb begin
		row_wd = row_rd;
		if (kind_q == KIND_INSTALL) begin
			row_wd[way*ENTB +: ENTB] = {1'b1, store_q, tag, stamp_q};
		end else begin
			row_wd[way*ENTB +: STAMP_BITS] = stamp_q;
			if (store_q) row_wd[way*ENTB + ENTB - 2] = 1'b1;
		end
		we    = cmd.clear_en || (cmd.eval && (kind_q == KIND_INSTALL || any_hit));
		waddr = cmd.clear_en ? clr_q : set_q;
		if (cmd.clear_en) row_wd = '0;
	end

	sact_ram #(.WIDTH(ROWB), .DEPTH(SETS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[$clog2(SETS)-1:0]),
		.wdata (row_wd),
		.raddr (set_q[$clog2(SETS)-1:0]),
		.rdata (row_rd)
	);

	assign status.clear_done = (clr_q == SB'(SETS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			lfsr_q <= LFSR_SEED;
			rd_q   <= '0;
			wr_q   <= '0;
			rdm_q  <= '0;
			wrm_q  <= '0;
			dev_q  <= '0;
		end else begin
			if (cmd.clear_en) clr_q <= clr_q + 1'b1;
			if (cmd.eval) begin
				if (kind_q == KIND_LOOKUP) begin
					if (store_q) begin
						wr_q <= wr_q + 1'b1;
						if (!any_hit) wrm_q <= wrm_q + 1'b1;
					end else begin
						rd_q <= rd_q + 1'b1;
						if (!any_hit) rdm_q <= rdm_q + 1'b1;
					end
				end else begin
					if (policy == POLICY_RANDOM) lfsr_q <= lfsr_n;
					if (v[vway] && d[vway]) dev_q <= dev_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q  <= req.kind;
			store_q <= req.is_store;
			addr_q  <= ADDRESS_BITS'(req.line_address);
			stamp_q <= STAMP_BITS'(req.now);
			set_q   <= SB'(ADDRESS_BITS'(req.line_address)) & SB'((SETS - 1));
		end
		if (cmd.eval) begin
			if (kind_q == KIND_LOOKUP) begin
				hit_q <= any_hit;
				evv_q <= 1'b0;
				evd_q <= 1'b0;
				eva_q <= '0;
			end else begin
				hit_q <= 1'b0;
				evv_q <= v[vway];
				evd_q <= d[vway];
				eva_q <= 32'(ev_full);
			end
		end
	end

	assign rsp = '{hit: hit_q, evicted_valid: evv_q, evicted_dirty: evd_q,
		evicted_line_address: eva_q, read_accesses: rd_q, write_accesses: wr_q,
		read_misses: rdm_q, write_misses: wrm_q, dirty_evictions: dev_q};
endmodule

// ----- hw/rtl/set_assoc_cache_tag_store.sv -----
// channel | dir | handshake              | payload
// req     | in  | req_valid / req_ready  | sact_pkg::req_t
// rsp     | out | rsp_valid / rsp_ready  | sact_pkg::rsp_t
// cfg     | in  | cfg_valid / cfg_ready  | replace_policy (1 bit)
//
// Each transaction runs through accept, the registered set read from the tag
// RAM, compare and write-back, then the response is held until taken.
// After reset a clearing pass writes every set once, during which req_ready
// stays low. A stalled response holds the block.
module set_assoc_cache_tag_store #(
	parameter int SET_COUNT    = sact_pkg::SET_COUNT_DEF,
	parameter int WAY_COUNT    = sact_pkg::WAY_COUNT_DEF,
	parameter int ADDRESS_BITS = sact_pkg::ADDRESS_BITS_DEF,
	parameter int STAMP_BITS   = sact_pkg::STAMP_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sact_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output sact_pkg::rsp_t   rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);
	import sact_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    policy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        policy_q <= POLICY_LRU;
		else if (cfg_valid) policy_q <= cfg_data;
	end

	sact_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sact_datapath #(
		.SET_COUNT    (SET_COUNT),
		.WAY_COUNT    (WAY_COUNT),
		.ADDRESS_BITS (ADDRESS_BITS),
		.STAMP_BITS   (STAMP_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.req    (req),
		.policy (policy_q),
		.rsp    (rsp)
	);

	a_one_owner: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("ready and response overlap");
	a_rsp_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |=> rsp_valid) else $error("response missing after compare");
	a_take_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> ##1 cmd.eval) else $error("set read skipped");
endmodule

// ----- tb/tag_store_checker.sv -----
`timescale 1ns / 100ps

module tag_store_checker #(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  sact_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  sact_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic            cfg_data,
	output int              mismatches,
	output int              pending
);
	import sact_pkg::*;

	localparam int IB = set_index_width(SETS);
	localparam int LINES = (1 << IB) * WAYS;

	logic        way_valid [LINES];
	logic        way_dirty [LINES];
	logic [31:0] way_tag   [LINES];
	logic [31:0] way_stamp [LINES];
	logic [15:0] victim_lfsr;
	logic        policy;
	logic [31:0] n_rd, n_wr, n_rdmiss, n_wrmiss, n_dirtyev;
	rsp_t        expected_rsp [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic int choose_victim(input int base);
		int v;
		logic [31:0] oldest;
		if (policy == POLICY_RANDOM) begin
			victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TAPS) : (victim_lfsr >> 1);
			return victim_lfsr % WAYS;
		end
		v = 0;
		oldest = way_stamp[base];
		for (int w = 0; w < WAYS; w++) begin
			if (!way_valid[base + w]) return w;
			if (way_stamp[base + w] < oldest) begin
				oldest = way_stamp[base + w];
				v = w;
			end
		end
		return v;
	endfunction

	function automatic rsp_t access_line(input req_t r);
		rsp_t o;
		int set, base, k;
		logic [31:0] tag;
		o = '0;
		set = r.line_address & ((1 << IB) - 1);
		tag = r.line_address >> IB;
		base = set * WAYS;
		if (r.kind == KIND_LOOKUP) begin
			if (r.is_store) n_wr++; else n_rd++;
			for (int w = 0; w < WAYS; w++) begin
				k = base + w;
				if (way_valid[k] && way_tag[k] == tag) begin
					if (r.is_store) way_dirty[k] = 1'b1;
					way_stamp[k] = r.now;
					o.hit = 1'b1;
					break;
				end
			end
			if (!o.hit) begin
				if (r.is_store) n_wrmiss++; else n_rdmiss++;
			end
		end else begin
			k = base + choose_victim(base);
			o.evicted_valid = way_valid[k];
			o.evicted_dirty = way_dirty[k];
			o.evicted_line_address = (way_tag[k] << IB) | set;
			if (way_valid[k] && way_dirty[k]) n_dirtyev++;
			way_valid[k] = 1'b1;
			way_dirty[k] = r.is_store;
			way_stamp[k] = r.now;
			way_tag[k] = tag;
		end
		o.read_accesses = n_rd;
		o.write_accesses = n_wr;
		o.read_misses = n_rdmiss;
		o.write_misses = n_wrmiss;
		o.dirty_evictions = n_dirtyev;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				way_valid[i] = 1'b0;
				way_dirty[i] = 1'b0;
				way_tag[i] = '0;
				way_stamp[i] = '0;
			end
			victim_lfsr = LFSR_SEED;
			policy = POLICY_LRU;
			{n_rd, n_wr, n_rdmiss, n_wrmiss, n_dirtyev} = '0;
			expected_rsp.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) policy = cfg_data;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					report("response count", 32'd1, 32'd0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.hit !== want.hit) report("hit", rsp.hit, want.hit);
					if (rsp.evicted_valid !== want.evicted_valid)
						report("evicted_valid", rsp.evicted_valid, want.evicted_valid);
					if (rsp.evicted_dirty !== want.evicted_dirty)
						report("evicted_dirty", rsp.evicted_dirty, want.evicted_dirty);
					if (rsp.evicted_line_address !== want.evicted_line_address)
						report("evicted_line_address", rsp.evicted_line_address,
							want.evicted_line_address);
					if (rsp.read_accesses !== want.read_accesses)
						report("read_accesses", rsp.read_accesses, want.read_accesses);
					if (rsp.write_accesses !== want.write_accesses)
						report("write_accesses", rsp.write_accesses, want.write_accesses);
					if (rsp.read_misses !== want.read_misses)
						report("read_misses", rsp.read_misses, want.read_misses);
					if (rsp.write_misses !== want.write_misses)
						report("write_misses", rsp.write_misses, want.write_misses);
					if (rsp.dirty_evictions !== want.dirty_evictions)
						report("dirty_evictions", rsp.dirty_evictions, want.dirty_evictions);
				end
			end
			if (req_valid && req_ready) expected_rsp.push_back(access_line(req));
			pending = expected_rsp.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import sact_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	int   mismatches;
	int   pending;
	int   idle_cycles = 0;
	bit   hold_off = 1'b0;
	logic [31:0] time_now = 32'd1;
	logic [31:0] recent_lines [$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	set_assoc_cache_tag_store dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	tag_store_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				rsp_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (wait_n > 0) begin
				rsp_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// valid stays up across back-to-back transactions; drop it only before a gap
	task automatic send_req(input logic k, input logic [31:0] addr, input logic st,
			input logic [31:0] stamp, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		if ($urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{kind: k, line_address: addr, is_store: st, now: stamp};
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (k == KIND_INSTALL || $urandom_range(0, 3) == 0) begin
			recent_lines.push_back(addr);
			if (recent_lines.size() > 48) void'(recent_lines.pop_front());
		end
	endtask

	task automatic write_policy(input logic p);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly hits and installs into a few sets; stamps rise with some reuse
	task automatic random_item(input bit no_gap);
		logic [31:0] addr;
		logic [31:0] stamp;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5 && recent_lines.size() > 0)
			addr = recent_lines[$urandom_range(0, recent_lines.size() - 1)];
		else if (pick < 8)
			addr = ($urandom_range(0, 31) << 6) | $urandom_range(0, 3);
		else
			addr = $urandom;
		time_now = time_now + $urandom_range(0, 3);
		stamp = ($urandom_range(0, 15) == 0) ? $urandom : time_now;
		send_req($urandom_range(0, 2) == 0, addr, $urandom_range(0, 1), stamp, no_gap);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_policy(POLICY_LRU);
		// directed: field extremes, miss, install, hit, dirty eviction, ties
		send_req(KIND_LOOKUP, 32'h0, 1'b0, 32'h0, 0);
		send_req(KIND_INSTALL, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0);
		send_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0, 0);
		send_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'h5, 0);
		for (int i = 0; i < 4; i++)
			send_req(KIND_INSTALL, (i << 6) | 32'h5, i[0], 32'h7, 0);
		send_req(KIND_INSTALL, 32'h0000_1105, 1'b0, 32'h8, 0);
		send_req(KIND_INSTALL, 32'h0000_1145, 1'b1, 32'h9, 0);
		send_req(KIND_LOOKUP, 32'h0000_0085, 1'b1, 32'h1, 0);
		send_req(KIND_INSTALL, 32'h0000_2005, 1'b0, 32'hA, 0);
		send_req(KIND_INSTALL, 32'h0000_0000, 1'b0, 32'h0, 0);
		send_req(KIND_LOOKUP, 32'hAAAA_AAAA, 1'b1, 32'h5555_5555, 0);
		send_req(KIND_INSTALL, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA, 0);

		write_policy(POLICY_RANDOM);
		for (int i = 0; i < 10; i++)
			send_req(KIND_INSTALL, (i << 6) | 32'h3, 1'b1, i, 0);

		for (int phase = 0; phase < 4; phase++) begin
			write_policy(phase[0] ? POLICY_RANDOM : POLICY_LRU);
			if (phase == 1) hold_off = 1'b1;
			for (int i = 0; i < 430; i++)
				random_item(phase == 1 && i < 200 || (i % 100) < 20);
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/sact_pkg.sv
hw/rtl/sact_ram.sv
hw/rtl/sact_ctrl.sv
hw/rtl/sact_datapath.sv
hw/rtl/set_assoc_cache_tag_store.sv
tb/tag_store_checker.sv
tb/tb.sv
